// ===== hw/rtl/lowercase_djb2_substring_hash_scanner_top_macros.svh =====
// Assertion macros used by the scanner back end.
`ifndef LOWERCASE_DJB2_SUBSTRING_HASH_SCANNER_TOP_MACROS_SVH
`define LOWERCASE_DJB2_SUBSTRING_HASH_SCANNER_TOP_MACROS_SVH
// Property checked on every rising clock edge outside reset.
`define DJB_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("djb assertion failed");
// Condition that must never hold.
`define DJB_NEVER(lbl, cond) \
   `DJB_ASSERT(lbl, !(cond))
`endif

// ===== hw/rtl/djb_pkg.sv =====
// Types and constants shared by the substring hash scanner.
`default_nettype none
package djb_pkg;
   localparam logic [1:0] KIND_LOAD    = 2'd0;
   localparam logic [1:0] KIND_CHAR    = 2'd1;
   localparam logic [1:0] KIND_RESTART = 2'd2;

   localparam logic [31:0] HASH_SEED  = 32'h0000_1505;
   localparam logic [31:0] HASH_MUL   = 32'h0000_0021;
   localparam logic [7:0]  CHAR_LOW   = 8'd32;
   localparam logic [7:0]  CHAR_HIGH  = 8'd127;
   localparam logic [7:0]  UPPER_A    = 8'h41;
   localparam logic [7:0]  UPPER_Z    = 8'h5A;
   localparam logic [7:0]  CASE_DELTA = 8'd32;

   localparam int CMDQ_DEPTH = 4;
   localparam int CMDQ_AW    = 2;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_CHAR,
      OP_BAD,
      OP_RESTART
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  idx;
      logic [31:0] ehash;
      logic        evalid;
      logic [7:0]  ch;
   } cmd_type;

   typedef struct packed {
      logic        valid;
      cmd_type     cmd;
   } cmd_link_type;

   typedef struct packed {
      logic [31:0] start;
      logic [6:0]  len;
      logic [31:0] hash;
      logic        last;
   } res_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SWEEP,
      ST_EMIT
   } state_type;
endpackage
`default_nettype wire

// ===== hw/rtl/djb_front.sv =====
// Front end: takes requests, classifies and lowercases them into a command queue.
`default_nettype none
module djb_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   output logic                     full,
   input  wire logic [1:0]          req_kind,
   input  wire logic [7:0]          req_entry_index,
   input  wire logic [31:0]         req_entry_hash,
   input  wire logic                req_entry_valid,
   input  wire logic [7:0]          req_char_value,
   output djb_pkg::cmd_link_type    link,
   input  wire logic                cmd_pop
);
   import djb_pkg::*;

   cmd_type             q_ff [CMDQ_DEPTH];
   logic [CMDQ_AW-1:0]  wr_ff, wr_in;
   logic [CMDQ_AW-1:0]  rd_ff, rd_in;
   logic [CMDQ_AW:0]    cnt_ff, cnt_in;
   cmd_type             new_cmd;
   logic                enq;
   logic                deq;

   assign full = (cnt_ff == (CMDQ_AW+1)'(CMDQ_DEPTH));

   always_comb begin
      new_cmd.idx    = req_entry_index;
      new_cmd.ehash  = req_entry_hash;
      new_cmd.evalid = req_entry_valid;
      new_cmd.ch     = req_char_value;
      if (req_char_value >= UPPER_A && req_char_value <= UPPER_Z) begin
         new_cmd.ch = req_char_value + CASE_DELTA;
      end
      unique case (req_kind)
         KIND_LOAD:    new_cmd.op = OP_LOAD;
         KIND_CHAR:    new_cmd.op = (req_char_value < CHAR_LOW || req_char_value > CHAR_HIGH)
                                    ? OP_BAD : OP_CHAR;
         KIND_RESTART: new_cmd.op = OP_RESTART;
         default:      new_cmd.op = OP_LOAD;
      endcase
   end

   // unused kind is taken and dropped
   assign enq = push && !full && (req_kind == KIND_LOAD || req_kind == KIND_CHAR ||
                                  req_kind == KIND_RESTART);
   assign deq = cmd_pop && (cnt_ff != '0);

   always_comb begin
      wr_in  = enq ? wr_ff + CMDQ_AW'(1) : wr_ff;
      rd_in  = deq ? rd_ff + CMDQ_AW'(1) : rd_ff;
      cnt_in = cnt_ff;
      if (enq && !deq) begin
         cnt_in = cnt_ff + (CMDQ_AW+1)'(1);
      end else if (deq && !enq) begin
         cnt_in = cnt_ff - (CMDQ_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         q_ff[wr_ff] <= new_cmd;
      end
   end

   assign link.valid = (cnt_ff != '0);
   assign link.cmd   = q_ff[rd_ff];
endmodule
`default_nettype wire

// ===== hw/rtl/djb_back.sv =====
// Back end: lane hashes, target table sweep and ordered match output.
`default_nettype none
`include "lowercase_djb2_substring_hash_scanner_top_macros.svh"
module djb_back #(
   parameter int MAX_LEN       = 64,
   parameter int TABLE_ENTRIES = 256
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire djb_pkg::cmd_link_type link,
   output logic                     cmd_pop,
   output logic                     empty,
   input  wire logic                pop,
   output djb_pkg::res_type         res
);
   import djb_pkg::*;

   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int LW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam logic [AW-1:0] ADDR_LAST = AW'(TABLE_ENTRIES - 1);

   state_type           state_ff, state_in;
   logic [31:0]         lane_hash_ff [MAX_LEN];
   logic [31:0]         lane_hash_in [MAX_LEN];
   logic [MAX_LEN-1:0]  lane_alive_ff;
   logic [31:0]         emit_hash_ff [MAX_LEN];
   logic [MAX_LEN-1:0]  hit_ff, hit_in, cmp_vec;
   logic [LW-1:0]       lane_ff;
   logic [31:0]         pos_ff;
   logic [31:0]         cpos_ff;
   logic [AW-1:0]       addr_ff;
   logic                issue_ff;
   logic                rd_vld_ff;
   logic [32:0]         rd_data_ff;
   logic [32:0]         mem [TABLE_ENTRIES];
   logic                mem_we;
   logic [AW-1:0]       mem_waddr;
   logic [32:0]         mem_wdata;
   logic                take;
   logic                is_char;
   logic                adv;
   logic                emit_push;
   logic                emit_done;
   logic                rest_clear;
   res_type             of_ff [2];
   logic                of_wr_ff, of_rd_ff;
   logic [1:0]          of_cnt_ff;
   logic                of_full;
   logic                of_pop;
   res_type             new_res;

   assign take    = (state_ff == ST_IDLE) && link.valid;
   assign cmd_pop = take;
   assign is_char = take && (link.cmd.op == OP_CHAR);

   // next lane hashes for a valid character: h*33 + c
   always_comb begin
      lane_hash_in[0] = 32'(HASH_SEED * HASH_MUL) + {24'd0, link.cmd.ch};
      for (int j = 1; j < MAX_LEN; j++) begin
         lane_hash_in[j] = lane_alive_ff[j-1]
            ? (lane_hash_ff[j-1] << 5) + lane_hash_ff[j-1] + {24'd0, link.cmd.ch}
            : '0;
      end
   end

   always_comb begin
      for (int j = 0; j < MAX_LEN; j++) begin
         cmp_vec[j] = lane_alive_ff[j] && (lane_hash_ff[j] == rd_data_ff[31:0]);
      end
   end

   assign of_full    = (of_cnt_ff == 2'd2);
   assign rest_clear = ((hit_ff << 1) == '0);
   assign adv        = (state_ff == ST_EMIT) && (!hit_ff[MAX_LEN-1] || !of_full);
   assign emit_push  = (state_ff == ST_EMIT) && hit_ff[MAX_LEN-1] && !of_full;
   assign emit_done  = adv && rest_clear;

   always_comb begin
      hit_in = hit_ff;
      if (state_ff == ST_SWEEP && rd_vld_ff && rd_data_ff[32]) begin
         hit_in = hit_ff | cmp_vec;
      end else if (adv) begin
         hit_in = hit_ff << 1;
      end else if (is_char) begin
         hit_in = '0;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (addr_ff == ADDR_LAST) state_in = ST_IDLE;
         ST_IDLE:  if (is_char) state_in = ST_SWEEP;
         ST_SWEEP: if (!issue_ff) state_in = ST_EMIT;
         ST_EMIT:  if (emit_done) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // table port: clearing pass, loads, and the sweep read
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = '0;
      if (state_ff == ST_CLEAR) begin
         mem_we = 1'b1;
      end else if (take && link.cmd.op == OP_LOAD &&
                   {24'd0, link.cmd.idx} < 32'(TABLE_ENTRIES)) begin
         mem_we    = 1'b1;
         mem_waddr = AW'(link.cmd.idx);
         mem_wdata = {link.cmd.evalid, link.cmd.ehash};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff       <= '0;
         issue_ff      <= 1'b0;
         rd_vld_ff     <= 1'b0;
         lane_alive_ff <= '0;
         pos_ff        <= '0;
         hit_ff        <= '0;
      end else begin
         hit_ff    <= hit_in;
         rd_vld_ff <= (state_ff == ST_SWEEP) && issue_ff;
         if (state_ff == ST_CLEAR) begin
            addr_ff <= addr_ff + AW'(1);
         end else if (is_char) begin
            addr_ff  <= '0;
            issue_ff <= 1'b1;
         end else if (state_ff == ST_SWEEP && issue_ff) begin
            if (addr_ff == ADDR_LAST) begin
               issue_ff <= 1'b0;
            end else begin
               addr_ff <= addr_ff + AW'(1);
            end
         end
         if (take) begin
            case (link.cmd.op)
               OP_CHAR: begin
                  lane_alive_ff <= MAX_LEN'({lane_alive_ff, 1'b1});
                  pos_ff        <= pos_ff + 32'd1;
               end
               OP_BAD: begin
                  lane_alive_ff <= '0;
                  pos_ff        <= pos_ff + 32'd1;
               end
               OP_RESTART: begin
                  lane_alive_ff <= '0;
                  pos_ff        <= '0;
               end
               default: ;
            endcase
         end
      end
   end

   // payload: lane hashes, emit copy and lane counter
   always_ff @(posedge clock) begin
      if (take && (link.cmd.op == OP_BAD || link.cmd.op == OP_RESTART)) begin
         for (int j = 0; j < MAX_LEN; j++) begin
            lane_hash_ff[j] <= '0;
         end
      end else if (is_char) begin
         for (int j = 0; j < MAX_LEN; j++) begin
            lane_hash_ff[j] <= lane_hash_in[j];
            emit_hash_ff[j] <= lane_hash_in[j];
         end
         cpos_ff <= pos_ff;
         lane_ff <= LW'(MAX_LEN - 1);
      end else if (adv) begin
         for (int j = MAX_LEN - 1; j > 0; j--) begin
            emit_hash_ff[j] <= emit_hash_ff[j-1];
         end
         lane_ff <= lane_ff - LW'(1);
      end
   end

   // top of the emit copy is always the lane under inspection
   always_comb begin
      new_res.start = cpos_ff - 32'(lane_ff);
      new_res.len   = 7'(8'(lane_ff) + 8'd1);
      new_res.hash  = emit_hash_ff[MAX_LEN-1];
      new_res.last  = rest_clear;
   end

   assign of_pop = pop && (of_cnt_ff != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         of_wr_ff  <= 1'b0;
         of_rd_ff  <= 1'b0;
         of_cnt_ff <= 2'd0;
      end else begin
         if (emit_push) of_wr_ff <= ~of_wr_ff;
         if (of_pop)    of_rd_ff <= ~of_rd_ff;
         if (emit_push && !of_pop) begin
            of_cnt_ff <= of_cnt_ff + 2'd1;
         end else if (of_pop && !emit_push) begin
            of_cnt_ff <= of_cnt_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit_push) begin
         of_ff[of_wr_ff] <= new_res;
      end
   end

   assign empty = (of_cnt_ff == 2'd0);
   assign res   = of_ff[of_rd_ff];

   `DJB_NEVER(a_of_over, of_cnt_ff == 2'd3)
   `DJB_ASSERT(a_rd_in_sweep, rd_vld_ff |-> state_ff == ST_SWEEP)
   `DJB_ASSERT(a_lane0_live, is_char |=> lane_alive_ff[0])
endmodule
`default_nettype wire

// ===== hw/rtl/lowercase_djb2_substring_hash_scanner_top.sv =====
// Top level of the substring hash scanner.
// Usage:
//   Requests enter through push/full (accepted when push is high and full is
//   low). kind 0 loads a target table slot, kind 1 is a stream character,
//   kind 2 restarts the stream. Matches leave through empty/pop with the
//   oldest match on the rsp_ ports while empty is low.
//   A character is held in a small command queue, then the back end sweeps
//   the whole target table, one entry a cycle, comparing it against every
//   open lane at once, and finally walks the lanes longest first, one lane a
//   cycle, waiting at a match while the match queue is full. Loads and
//   restarts need no sweep. After reset the back end clears every table
//   entry; requests are queued meanwhile (up to four) and full rises after
//   that. If pop stays low the two-entry match queue fills and the lane walk
//   stalls; requests keep queueing until the command queue is full.
`default_nettype none
module lowercase_djb2_substring_hash_scanner_top #(
   parameter int MAX_LEN       = 64,
   parameter int TABLE_ENTRIES = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [1:0]  req_kind,
   input  wire logic [7:0]  req_entry_index,
   input  wire logic [31:0] req_entry_hash,
   input  wire logic        req_entry_valid,
   input  wire logic [7:0]  req_char_value,
   output logic             empty,
   input  wire logic        pop,
   output logic [31:0]      rsp_start_offset,
   output logic [6:0]       rsp_match_length,
   output logic [31:0]      rsp_match_hash,
   output logic             rsp_last
);
   import djb_pkg::*;

   cmd_link_type link;
   logic         cmd_pop;
   res_type      res;

   djb_front u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_kind        (req_kind),
      .req_entry_index (req_entry_index),
      .req_entry_hash  (req_entry_hash),
      .req_entry_valid (req_entry_valid),
      .req_char_value  (req_char_value),
      .link            (link),
      .cmd_pop         (cmd_pop)
   );

   djb_back #(
      .MAX_LEN       (MAX_LEN),
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .link    (link),
      .cmd_pop (cmd_pop),
      .empty   (empty),
      .pop     (pop),
      .res     (res)
   );

   assign rsp_start_offset = res.start;
   assign rsp_match_length = res.len;
   assign rsp_match_hash   = res.hash;
   assign rsp_last         = res.last;
endmodule
`default_nettype wire
